/* hdl/rau_pkg.sv */
// Package with the beat types, codes and command set of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

   // Action codes of a request beat.
   localparam logic [3:0] ACT_ADD = 4'd0;
   localparam logic [3:0] ACT_SUB = 4'd1;
   localparam logic [3:0] ACT_MUL = 4'd2;
   localparam logic [3:0] ACT_DIV = 4'd3;
   localparam logic [3:0] ACT_NEG = 4'd4;
   localparam logic [3:0] ACT_EQ  = 4'd5;
   localparam logic [3:0] ACT_LT  = 4'd6;
   localparam logic [3:0] ACT_LE  = 4'd7;
   localparam logic [3:0] ACT_GT  = 4'd8;
   localparam logic [3:0] ACT_GE  = 4'd9;

   // Status codes of a response beat.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   // Width of the intermediate products and of the divider.
   localparam int WIDE_W    = 64;
   localparam int DIV_STEPS = WIDE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               cmp_true;
      logic [1:0]         status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL_LEFT,
      CMD_MUL_RIGHT,
      CMD_MUL_DEN,
      CMD_MUL_NUM,
      CMD_FORM,
      CMD_GCD_STEP,
      CMD_DIV_INIT_NUM,
      CMD_DIV_INIT_DEN,
      CMD_DIV_STEP,
      CMD_SAVE_NUM,
      CMD_SAVE_DEN,
      CMD_EMIT_ERR,
      CMD_EMIT_NEG,
      CMD_EMIT_CMP,
      CMD_EMIT_ARITH
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] action;
      logic       den_zero;
      logic       b_num_zero;
      logic       mag_zero;
      logic       gcd_done;
   } dp_status_type;

endpackage

/* hdl/rau_datapath.sv */
// Datapath: shared multiplier, binary gcd unit, restoring divider and result register.
`timescale 1ns / 1ps
module rau_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  rau_pkg::cmd_type       cmd,
   input  rau_pkg::req_type       req_data,
   output rau_pkg::dp_status_type status,
   output rau_pkg::rsp_type       rsp_data
);
   import rau_pkg::*;

   localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (VALUE_WIDTH - 1);

   req_type                   op_ff;
   logic signed [WIDE_W-1:0]  left_ff, right_ff, pden_ff, pnum_ff;
   logic [WIDE_W-1:0]         nm_ff, dm_ff, nq_ff, dq_ff;
   logic                      neg_ff;
   logic [WIDE_W-1:0]         x_ff, y_ff, g_ff;
   logic [5:0]                k_ff;
   logic [WIDE_W:0]           rem_ff;
   logic [WIDE_W-1:0]         quo_ff;
   rsp_type                   rsp_ff;

   logic signed [32:0]        mul_a, mul_b;
   logic signed [65:0]        mul_p;
   logic signed [WIDE_W-1:0]  form_num, form_den;
   logic [WIDE_W-1:0]         gcd_x_in, gcd_y_in;
   logic [5:0]                gcd_k_in;
   logic [WIDE_W:0]           div_trial;
   logic                      div_fit;
   logic                      cmp_bit;

   // Result of an arithmetic beat with the range check applied.
   function automatic rsp_type emit_fn(logic neg, logic [WIDE_W-1:0] nm,
                                       logic [WIDE_W-1:0] dm);
      rsp_type          r;
      logic             n;
      logic [WIDE_W-1:0] d;
      logic [WIDE_W-1:0] sv;
      n = neg;
      d = dm;
      if (nm == '0) begin
         n = 1'b0;
         d = WIDE_W'(1);
      end
      sv = n ? (WIDE_W'(0) - nm) : nm;
      r.cmp_true = 1'b0;
      if (d > LIM - 1 || (n ? nm > LIM : nm > LIM - 1)) begin
         r.res_num = '0;
         r.res_den = 31'd1;
         r.status  = STATUS_OVF;
      end else begin
         r.res_num = sv[31:0];
         r.res_den = d[30:0];
         r.status  = STATUS_OK;
      end
      return r;
   endfunction

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd)
         CMD_MUL_LEFT: begin
            mul_a = {op_ff.a_num[31], op_ff.a_num};
            mul_b = {2'b00, op_ff.b_den};
         end
         CMD_MUL_RIGHT: begin
            mul_a = {2'b00, op_ff.a_den};
            mul_b = {op_ff.b_num[31], op_ff.b_num};
         end
         CMD_MUL_DEN: begin
            mul_a = {2'b00, op_ff.a_den};
            mul_b = {2'b00, op_ff.b_den};
         end
         default: begin
            mul_a = {op_ff.a_num[31], op_ff.a_num};
            mul_b = {op_ff.b_num[31], op_ff.b_num};
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Unreduced numerator and denominator for the arithmetic actions.
   always_comb begin
      unique case (op_ff.action)
         ACT_ADD: begin
            form_num = left_ff + right_ff;
            form_den = pden_ff;
         end
         ACT_SUB: begin
            form_num = left_ff - right_ff;
            form_den = pden_ff;
         end
         ACT_MUL: begin
            form_num = pnum_ff;
            form_den = pden_ff;
         end
         default: begin
            form_num = left_ff;
            form_den = right_ff;
         end
      endcase
   end

   // One step of the binary gcd.
   always_comb begin
      gcd_x_in = x_ff;
      gcd_y_in = y_ff;
      gcd_k_in = k_ff;
      priority if (!x_ff[0] && !y_ff[0]) begin
         gcd_x_in = x_ff >> 1;
         gcd_y_in = y_ff >> 1;
         gcd_k_in = k_ff + 6'd1;
      end else if (!x_ff[0]) begin
         gcd_x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         gcd_y_in = y_ff >> 1;
      end else if (x_ff >= y_ff) begin
         gcd_x_in = (x_ff - y_ff) >> 1;
      end else begin
         gcd_y_in = (y_ff - x_ff) >> 1;
      end
   end

   // One restoring division step.
   assign div_trial = {rem_ff[WIDE_W-1:0], quo_ff[WIDE_W-1]};
   assign div_fit   = div_trial >= {1'b0, g_ff};

   // Comparison outcome.
   always_comb begin
      unique case (op_ff.action)
         ACT_EQ:  cmp_bit = (op_ff.a_num == op_ff.b_num) && (op_ff.a_den == op_ff.b_den);
         ACT_LT:  cmp_bit = left_ff < right_ff;
         ACT_LE:  cmp_bit = left_ff <= right_ff;
         ACT_GT:  cmp_bit = left_ff > right_ff;
         ACT_GE:  cmp_bit = left_ff >= right_ff;
         default: cmp_bit = 1'b0;
      endcase
   end

   // Datapath registers, updated by command.
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LOAD:      op_ff    <= req_data;
         CMD_MUL_LEFT:  left_ff  <= mul_p[WIDE_W-1:0];
         CMD_MUL_RIGHT: right_ff <= mul_p[WIDE_W-1:0];
         CMD_MUL_DEN:   pden_ff  <= mul_p[WIDE_W-1:0];
         CMD_MUL_NUM:   pnum_ff  <= mul_p[WIDE_W-1:0];
         CMD_FORM: begin
            nm_ff  <= form_num[WIDE_W-1] ? WIDE_W'(0) - form_num : form_num;
            dm_ff  <= form_den[WIDE_W-1] ? WIDE_W'(0) - form_den : form_den;
            nq_ff  <= form_num[WIDE_W-1] ? WIDE_W'(0) - form_num : form_num;
            x_ff   <= form_num[WIDE_W-1] ? WIDE_W'(0) - form_num : form_num;
            y_ff   <= form_den[WIDE_W-1] ? WIDE_W'(0) - form_den : form_den;
            k_ff   <= '0;
            neg_ff <= form_num[WIDE_W-1] ^ form_den[WIDE_W-1];
         end
         CMD_GCD_STEP: begin
            x_ff <= gcd_x_in;
            y_ff <= gcd_y_in;
            k_ff <= gcd_k_in;
         end
         CMD_DIV_INIT_NUM: begin
            g_ff   <= (x_ff | y_ff) << k_ff;
            rem_ff <= '0;
            quo_ff <= nm_ff;
         end
         CMD_DIV_INIT_DEN: begin
            rem_ff <= '0;
            quo_ff <= dm_ff;
         end
         CMD_DIV_STEP: begin
            rem_ff <= div_fit ? div_trial - {1'b0, g_ff} : div_trial;
            quo_ff <= {quo_ff[WIDE_W-2:0], div_fit};
         end
         CMD_SAVE_NUM: nq_ff <= quo_ff;
         CMD_SAVE_DEN: dq_ff <= quo_ff;
         CMD_EMIT_ERR: begin
            rsp_ff.res_num  <= '0;
            rsp_ff.res_den  <= 31'd1;
            rsp_ff.cmp_true <= 1'b0;
            rsp_ff.status   <= STATUS_ZERO;
         end
         CMD_EMIT_NEG: begin
            rsp_ff <= emit_fn(op_ff.a_num > 0,
                              op_ff.a_num[31] ? WIDE_W'(-64'(op_ff.a_num))
                                              : WIDE_W'(op_ff.a_num),
                              WIDE_W'(op_ff.a_den));
         end
         CMD_EMIT_CMP: begin
            rsp_ff.res_num  <= '0;
            rsp_ff.res_den  <= 31'd1;
            rsp_ff.cmp_true <= cmp_bit;
            rsp_ff.status   <= STATUS_OK;
         end
         CMD_EMIT_ARITH: rsp_ff <= emit_fn(neg_ff, nq_ff, dq_ff);
         default: ;
      endcase
   end

   // Status back to the controller.
   assign status.action     = op_ff.action;
   assign status.den_zero   = (op_ff.a_den == '0) || (op_ff.b_den == '0);
   assign status.b_num_zero = op_ff.b_num == '0;
   assign status.mag_zero   = nm_ff == '0;
   assign status.gcd_done   = (x_ff == '0) || (y_ff == '0);
   assign rsp_data          = rsp_ff;

endmodule

/* hdl/rau_controller.sv */
// Controller state machine that sequences the datapath for one request beat.
`timescale 1ns / 1ps
module rau_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::cmd_type      cmd
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MUL_L, ST_MUL_R, ST_MUL_D, ST_MUL_N, ST_FORM, ST_GCD,
      ST_DIV_INIT_N, ST_DIV_N, ST_SAVE_N, ST_DIV_INIT_D, ST_DIV_D, ST_SAVE_D, ST_FIN
   } state_type;

   state_type        state_ff;
   cmd_type          fin_kind_ff;
   logic [CNT_W-1:0] count_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Command decode from the current state.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:       cmd = req_valid ? CMD_LOAD : CMD_NONE;
         ST_MUL_L:      cmd = CMD_MUL_LEFT;
         ST_MUL_R:      cmd = CMD_MUL_RIGHT;
         ST_MUL_D:      cmd = CMD_MUL_DEN;
         ST_MUL_N:      cmd = CMD_MUL_NUM;
         ST_FORM:       cmd = CMD_FORM;
         ST_GCD:        cmd = (status.gcd_done || status.mag_zero) ? CMD_NONE : CMD_GCD_STEP;
         ST_DIV_INIT_N: cmd = CMD_DIV_INIT_NUM;
         ST_DIV_INIT_D: cmd = CMD_DIV_INIT_DEN;
         ST_DIV_N:      cmd = CMD_DIV_STEP;
         ST_DIV_D:      cmd = CMD_DIV_STEP;
         ST_SAVE_N:     cmd = CMD_SAVE_NUM;
         ST_SAVE_D:     cmd = CMD_SAVE_DEN;
         ST_FIN:        cmd = out_free ? fin_kind_ff : CMD_NONE;
         default:       cmd = CMD_NONE;
      endcase
   end

   // State, step counter and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_kind_ff  <= CMD_EMIT_ERR;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The response is raised as the finish state completes and dropped once taken.
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (status.den_zero) begin
                  fin_kind_ff <= CMD_EMIT_ERR;
                  state_ff    <= ST_FIN;
               end else if (status.action == ACT_NEG) begin
                  fin_kind_ff <= CMD_EMIT_NEG;
                  state_ff    <= ST_FIN;
               end else if (status.action == ACT_DIV && status.b_num_zero) begin
                  fin_kind_ff <= CMD_EMIT_ERR;
                  state_ff    <= ST_FIN;
               end else if (status.action > ACT_GE || status.action == ACT_EQ) begin
                  fin_kind_ff <= CMD_EMIT_CMP;
                  state_ff    <= ST_FIN;
               end else begin
                  state_ff <= ST_MUL_L;
               end
            end
            ST_MUL_L: state_ff <= ST_MUL_R;
            ST_MUL_R: state_ff <= ST_MUL_D;
            ST_MUL_D: state_ff <= ST_MUL_N;
            ST_MUL_N: begin
               if (status.action >= ACT_LT) begin
                  fin_kind_ff <= CMD_EMIT_CMP;
                  state_ff    <= ST_FIN;
               end else begin
                  state_ff <= ST_FORM;
               end
            end
            ST_FORM: state_ff <= ST_GCD;
            ST_GCD: begin
               if (status.mag_zero) begin
                  fin_kind_ff <= CMD_EMIT_ARITH;
                  state_ff    <= ST_FIN;
               end else if (status.gcd_done) begin
                  state_ff <= ST_DIV_INIT_N;
               end
            end
            ST_DIV_INIT_N: begin
               count_ff <= '0;
               state_ff <= ST_DIV_N;
            end
            ST_DIV_N: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_SAVE_N;
               end
            end
            ST_SAVE_N: state_ff <= ST_DIV_INIT_D;
            ST_DIV_INIT_D: begin
               count_ff <= '0;
               state_ff <= ST_DIV_D;
            end
            ST_DIV_D: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_SAVE_D;
               end
            end
            ST_SAVE_D: begin
               fin_kind_ff <= CMD_EMIT_ARITH;
               state_ff    <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // A new request is not taken while one is in work.
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // The result register is only written when it is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_EMIT_ERR || cmd == CMD_EMIT_NEG || cmd == CMD_EMIT_CMP ||
       cmd == CMD_EMIT_ARITH) |-> out_free)
      else $error("result overwritten before it was taken");

   // A response appears only as the finish state completes.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish state");
`endif

endmodule

/* hdl/rational_arithmetic_unit_core.sv */
// Top level of the rational arithmetic unit: controller and datapath.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------
//  req     | in        | req_valid / req_ready | req_data (rau_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (rau_pkg::rsp_type)
//
//  Add, subtract, multiply and divide use the shared multiplier, binary gcd
//  steps and, unless the numerator is zero, two 64-step restoring divisions.
//  Order comparisons use the shared multiplier only; equality, unused codes,
//  negate and errors go from the check straight to the finish state.
//  Reset is synchronous and active high and clears the controller only.
//  One request is in work at a time; a finished response waits in the output
//  register, and the next request is taken while it waits.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   cmd_type       cmd;
   dp_status_type status;

   // Sequencer.
   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   rau_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
